/* rtl/core/bicycle_pose_predict_core_assert.svh */
// ---------------------------------------------------------------------------
// bicycle_pose_predict_core_assert.svh
// Assertion macros for the pose predictor; empty bodies under synthesis.
// ---------------------------------------------------------------------------
`ifndef BICYCLE_POSE_PREDICT_CORE_ASSERT_SVH
`define BICYCLE_POSE_PREDICT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BPP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPP_ASSERT_NORST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPP_ASSERT(name, clk, rst, prop, msg)
`define BPP_ASSERT_NORST(name, clk, prop, msg)
`endif

`endif

/* rtl/core/bpp_pkg.sv */
// ---------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helpers of the bicycle pose predictor.
// ---------------------------------------------------------------------------
package bpp_pkg;

   localparam int CORDIC_STAGES = 28;
   localparam int Q_STEPS       = 87;
   localparam int R_STEPS       = 55;
   // registered stages ahead of the output register
   localparam int LAT           = 151;

   localparam logic signed [32:0] CORDIC_X0     = 33'sd652032874;
   localparam logic [29:0]        UNITS_PER_RAD = 30'd683565276;
   localparam logic [39:0]        RADIUS_MAX    = 40'hFF_FFFF_FFFF;

   localparam logic [1:0] CSR_WHEEL_BASE   = 2'd0;
   localparam logic [1:0] CSR_TIME_STEP    = 2'd1;
   localparam logic [1:0] CSR_STRAIGHT_THR = 2'd2;

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [33:0] z;
   } cordic_type;

   typedef struct packed {
      cordic_type v;
      logic       flip;
   } cordic_start_type;

   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } sm_type;

   typedef struct packed {
      logic [54:0] rem;
      logic [54:0] dvd;
      logic [54:0] dsr;
      logic [63:0] quo;
   } div_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [15:0]        head;
      logic [23:0]        dmag;
      logic               negd;
      logic               negs;
      logic               straight;
      logic               flip_a;
      logic               flip_b;
      logic               flip_c;
      logic [39:0]        r;
      logic [15:0]        head_out;
   } ctx_type;

   function automatic logic signed [33:0] atan_of(input logic [4:0] idx);
      logic signed [33:0] res;
      case (idx)
         5'd0:  res = 34'sd536870912;
         5'd1:  res = 34'sd316933406;
         5'd2:  res = 34'sd167458907;
         5'd3:  res = 34'sd85004756;
         5'd4:  res = 34'sd42667331;
         5'd5:  res = 34'sd21354465;
         5'd6:  res = 34'sd10679838;
         5'd7:  res = 34'sd5340245;
         5'd8:  res = 34'sd2670163;
         5'd9:  res = 34'sd1335087;
         5'd10: res = 34'sd667544;
         5'd11: res = 34'sd333772;
         5'd12: res = 34'sd166886;
         5'd13: res = 34'sd83443;
         5'd14: res = 34'sd41722;
         5'd15: res = 34'sd20861;
         5'd16: res = 34'sd10430;
         5'd17: res = 34'sd5215;
         5'd18: res = 34'sd2608;
         5'd19: res = 34'sd1304;
         5'd20: res = 34'sd652;
         5'd21: res = 34'sd326;
         5'd22: res = 34'sd163;
         5'd23: res = 34'sd81;
         5'd24: res = 34'sd41;
         5'd25: res = 34'sd20;
         5'd26: res = 34'sd10;
         5'd27: res = 34'sd5;
         default: res = '0;
      endcase
      return res;
   endfunction

   // fold quadrants 1 and 2 by half a turn; result negated at the end
   function automatic cordic_start_type cordic_start(input logic [31:0] ang);
      cordic_start_type res;
      logic [31:0]      a;
      res.flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      a = res.flip ? ang + 32'h8000_0000 : ang;
      res.v.x = CORDIC_X0;
      res.v.y = '0;
      res.v.z = {{2{a[31]}}, a};
      return res;
   endfunction

   function automatic sm_type to_sm(input logic signed [32:0] v, input logic flip);
      sm_type             res;
      logic signed [32:0] w;
      logic [32:0]        m;
      w = flip ? -v : v;
      m = w[32] ? 33'(-w) : w;
      res.neg = w[32];
      res.mag = m[30:0];
      return res;
   endfunction

endpackage

/* rtl/core/bpp_if.sv */
// ---------------------------------------------------------------------------
// bpp_if
// Request and response stream interfaces of the pose predictor.
// ---------------------------------------------------------------------------
interface bpp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] heading_in;
   logic signed [23:0] speed;
   logic signed [14:0] steer;

   modport source (output valid, pos_x, pos_y, heading_in, speed, steer, input ready);
   modport sink   (input valid, pos_x, pos_y, heading_in, speed, steer, output ready);
endinterface

interface bpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [15:0] new_heading;
   logic               saturated;

   modport source (output valid, new_x, new_y, new_heading, saturated, input ready);
   modport sink   (input valid, new_x, new_y, new_heading, saturated, output ready);
endinterface

/* rtl/core/bicycle_pose_predict_core.sv */
// ---------------------------------------------------------------------------
// bicycle_pose_predict_core
// Kinematic bicycle pose update, fully pipelined as a chain of cells.
//
//   channel  dir  word
//   req_     in   pos_x, pos_y, heading_in, speed, steer
//   rsp_     out  new_x, new_y, new_heading, saturated
//   csr_     in   wheel_base / time_step / straight_threshold writes
//
// One word per cycle sustained unless the output stalls; words pass the steer
// CORDIC (28 cells), the 87-cell beta divider, the half-angle CORDICs (28 cells).
// Synchronous reset clears the valid chain and resets the CSRs to their defaults.
// The pipeline stalls only when its last stage and the output register are
// both full and the response side is not ready.
// ---------------------------------------------------------------------------
`include "bicycle_pose_predict_core_assert.svh"

module bicycle_pose_predict_core
   import bpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wr_data,
   bpp_req_if.sink     req_chan,
   bpp_rsp_if.source   rsp_chan
);

   // ---------------- configuration
   logic [23:0] wb_ff, wb_in;
   logic [15:0] ts_ff, ts_in;
   logic [10:0] thr_ff, thr_in;

   always_comb begin
      wb_in  = wb_ff;
      ts_in  = ts_ff;
      thr_in = thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WHEEL_BASE:   wb_in  = csr_wr_data;
            CSR_TIME_STEP:    ts_in  = csr_wr_data[15:0];
            CSR_STRAIGHT_THR: thr_in = csr_wr_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff  <= 24'd32768;
         ts_ff  <= 16'd6554;
         thr_ff <= 11'd10;
      end else begin
         wb_ff  <= wb_in;
         ts_ff  <= ts_in;
         thr_ff <= thr_in;
      end
   end

   // ---------------- flow control
   logic [LAT-1:0] vld_ff;
   logic           out_valid_ff, out_valid_in;
   logic           adv;
   logic           out_load;

   assign out_load     = !out_valid_ff || rsp_chan.ready;
   assign adv          = out_load || !vld_ff[LAT-1];
   assign out_valid_in = out_load ? vld_ff[LAT-1] : out_valid_ff;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
         end
      end
   end

   // ---------------- input stage: distance, steer fold, straight test
   logic [23:0]        spd_mag;
   logic [39:0]        dsum;
   logic signed [14:0] st_fix;
   logic [14:0]        st_abs;
   cordic_start_type   sa;
   ctx_type            ctx0_in;

   always_comb begin
      spd_mag = req_chan.speed[23] ? 24'(-req_chan.speed) : req_chan.speed;
      dsum    = 40'(spd_mag) * 40'(ts_ff) + 40'd32768;
      // steering at minus a quarter turn behaves as the next code up
      st_fix  = (req_chan.steer == 15'sh4000) ? 15'sh4001 : req_chan.steer;
      st_abs  = st_fix[14] ? 15'(-st_fix) : st_fix;
      sa      = cordic_start({st_fix[14], st_fix, 16'h0000});
      ctx0_in          = '0;
      ctx0_in.px       = req_chan.pos_x;
      ctx0_in.py       = req_chan.pos_y;
      ctx0_in.head     = req_chan.heading_in;
      ctx0_in.dmag     = dsum[39:16];
      ctx0_in.negd     = req_chan.speed[23];
      ctx0_in.negs     = st_fix[14];
      ctx0_in.straight = st_abs <= 15'(thr_ff);
      ctx0_in.flip_a   = sa.flip;
   end

   // ---------------- steer CORDIC
   cordic_type ca [0:CORDIC_STAGES];
   cordic_type ca0_ff;
   ctx_type    ctxa_ff [0:CORDIC_STAGES];

   assign ca[0] = ca0_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cora
      bpp_cordic_cell u_cell (
         .clock     (clock),
         .en        (adv),
         .stage_idx (5'(k)),
         .prev      (ca[k]),
         .cur       (ca[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ca0_ff     <= sa.v;
         ctxa_ff[0] <= ctx0_in;
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            ctxa_ff[k+1] <= ctxa_ff[k];
         end
      end
   end

   // ---------------- numerator / denominator
   sm_type      cs_sm, ss_sm;
   logic [30:0] acs, ass;
   logic [23:0] wb_use;
   div_type     qd0_in, rd0_in;

   always_comb begin
      cs_sm  = to_sm(ca[CORDIC_STAGES].x, ctxa_ff[CORDIC_STAGES].flip_a);
      ss_sm  = to_sm(ca[CORDIC_STAGES].y, ctxa_ff[CORDIC_STAGES].flip_a);
      acs    = (cs_sm.mag == '0) ? 31'd1 : cs_sm.mag;
      ass    = (ss_sm.mag == '0) ? 31'd1 : ss_sm.mag;
      wb_use = (wb_ff == '0) ? 24'd1 : wb_ff;
      qd0_in.rem = '0;
      qd0_in.dvd = 55'(ctxa_ff[CORDIC_STAGES].dmag) * 55'(ass);
      qd0_in.dsr = 55'(wb_use) * 55'(acs);
      qd0_in.quo = '0;
      rd0_in.rem = '0;
      rd0_in.dvd = qd0_in.dsr;
      rd0_in.dsr = 55'(ass);
      rd0_in.quo = '0;
   end

   // ---------------- beta quotient and turn radius dividers
   div_type qd [0:Q_STEPS];
   div_type rd [0:R_STEPS];
   div_type qd0_ff, rd0_ff;
   ctx_type ctxd_ff [0:Q_STEPS];
   ctx_type ctx_r;
   logic [39:0] r_clamp;

   assign qd[0] = qd0_ff;
   assign rd[0] = rd0_ff;

   for (genvar k = 0; k < Q_STEPS; k++) begin : g_qdiv
      bpp_div_cell u_cell (
         .clock (clock),
         .en    (adv),
         .prev  (qd[k]),
         .cur   (qd[k+1])
      );
   end

   for (genvar k = 0; k < R_STEPS; k++) begin : g_rdiv
      bpp_div_cell u_cell (
         .clock (clock),
         .en    (adv),
         .prev  (rd[k]),
         .cur   (rd[k+1])
      );
   end

   assign r_clamp = (|rd[R_STEPS].quo[54:40]) ? RADIUS_MAX : rd[R_STEPS].quo[39:0];

   // radius joins the context where its divider ends
   always_comb begin
      ctx_r   = ctxd_ff[R_STEPS];
      ctx_r.r = r_clamp;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qd0_ff     <= qd0_in;
         rd0_ff     <= rd0_in;
         ctxd_ff[0] <= ctxa_ff[CORDIC_STAGES];
         for (int k = 0; k < Q_STEPS; k++) begin
            ctxd_ff[k+1] <= (k == R_STEPS) ? ctx_r : ctxd_ff[k];
         end
      end
   end

   // ---------------- beta scaling to binary angle
   logic [61:0] prod_hi, prod_lo;
   logic [31:0] p_hi_ff, p_hi_in;
   logic [29:0] p_lo_ff, p_lo_in;
   ctx_type     ctxb_ff;

   always_comb begin
      prod_hi = 62'(qd[Q_STEPS].quo[63:32]) * 62'(UNITS_PER_RAD);
      prod_lo = 62'(qd[Q_STEPS].quo[31:0]) * 62'(UNITS_PER_RAD);
      p_hi_in = prod_hi[31:0];
      p_lo_in = prod_lo[61:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         ctxb_ff <= ctxd_ff[Q_STEPS];
      end
   end

   // ---------------- heading, half angle, CORDIC starts
   logic [31:0]      bm, beta, half, h32, hsum;
   cordic_start_type sb, sc;
   ctx_type          ctxe0_in;

   always_comb begin
      bm   = p_hi_ff + 32'(p_lo_ff);
      beta = (ctxb_ff.negd != ctxb_ff.negs) ? 32'(0 - bm) : bm;
      half = ctxb_ff.straight ? 32'h0 : {beta[31], beta[31:1]};
      h32  = {ctxb_ff.head, 16'h0000};
      hsum = h32 + beta + 32'h0000_8000;
      sb   = cordic_start(half);
      sc   = cordic_start(h32 + half);
      ctxe0_in          = ctxb_ff;
      ctxe0_in.flip_b   = sb.flip;
      ctxe0_in.flip_c   = sc.flip;
      ctxe0_in.head_out = ctxb_ff.straight ? ctxb_ff.head : hsum[31:16];
   end

   cordic_type cb [0:CORDIC_STAGES];
   cordic_type cc [0:CORDIC_STAGES];
   cordic_type cb0_ff, cc0_ff;
   ctx_type    ctxe_ff [0:CORDIC_STAGES];

   assign cb[0] = cb0_ff;
   assign cc[0] = cc0_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_corbc
      bpp_cordic_cell u_half (
         .clock     (clock),
         .en        (adv),
         .stage_idx (5'(k)),
         .prev      (cb[k]),
         .cur       (cb[k+1])
      );
      bpp_cordic_cell u_dir (
         .clock     (clock),
         .en        (adv),
         .stage_idx (5'(k)),
         .prev      (cc[k]),
         .cur       (cc[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb0_ff     <= sb.v;
         cc0_ff     <= sc.v;
         ctxe_ff[0] <= ctxe0_in;
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            ctxe_ff[k+1] <= ctxe_ff[k];
         end
      end
   end

   // ---------------- chord length partial products
   sm_type      sh_sm;
   sm_type      cm_ff, cm_in, sm_ff, sm_in;
   logic [38:0] rh_ff, rh_in;
   logic [62:0] rl_ff, rl_in;
   logic        negc_ff, negc_in;
   ctx_type     ctxg_ff;

   always_comb begin
      sh_sm   = to_sm(cb[CORDIC_STAGES].y, ctxe_ff[CORDIC_STAGES].flip_b);
      cm_in   = to_sm(cc[CORDIC_STAGES].x, ctxe_ff[CORDIC_STAGES].flip_c);
      sm_in   = to_sm(cc[CORDIC_STAGES].y, ctxe_ff[CORDIC_STAGES].flip_c);
      rh_in   = 39'(ctxe_ff[CORDIC_STAGES].r[39:32]) * 39'(sh_sm.mag);
      rl_in   = 63'(ctxe_ff[CORDIC_STAGES].r[31:0]) * 63'(sh_sm.mag);
      negc_in = ctxe_ff[CORDIC_STAGES].negs != sh_sm.neg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rh_ff   <= rh_in;
         rl_ff   <= rl_in;
         negc_ff <= negc_in;
         cm_ff   <= cm_in;
         sm_ff   <= sm_in;
         ctxg_ff <= ctxe_ff[CORDIC_STAGES];
      end
   end

   // ---------------- travel magnitude select
   logic [42:0] chm;
   logic [42:0] mag_ff, mag_in;
   logic        negm_ff, negm_in;
   sm_type      cm2_ff, sm2_ff;
   ctx_type     ctxh_ff;

   always_comb begin
      chm     = {1'b0, rh_ff, 3'b000} + 43'(rl_ff[62:29]);
      mag_in  = ctxg_ff.straight ? 43'(ctxg_ff.dmag) : chm;
      negm_in = ctxg_ff.straight ? ctxg_ff.negd : negc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_in;
         negm_ff <= negm_in;
         cm2_ff  <= cm_ff;
         sm2_ff  <= sm_ff;
         ctxh_ff <= ctxg_ff;
      end
   end

   // ---------------- position delta partial products
   logic [41:0] hx_ff, hx_in, hy_ff, hy_in;
   logic [62:0] lx_ff, lx_in, ly_ff, ly_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   ctx_type     ctxf_ff;

   always_comb begin
      hx_in   = 42'(mag_ff[42:32]) * 42'(cm2_ff.mag);
      lx_in   = 63'(mag_ff[31:0]) * 63'(cm2_ff.mag);
      hy_in   = 42'(mag_ff[42:32]) * 42'(sm2_ff.mag);
      ly_in   = 63'(mag_ff[31:0]) * 63'(sm2_ff.mag);
      negx_in = negm_ff != cm2_ff.neg;
      negy_in = negm_ff != sm2_ff.neg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hx_ff   <= hx_in;
         lx_ff   <= lx_in;
         hy_ff   <= hy_in;
         ly_ff   <= ly_in;
         negx_ff <= negx_in;
         negy_ff <= negy_in;
         ctxf_ff <= ctxh_ff;
      end
   end

   // ---------------- signed deltas
   logic [44:0] mx, my;
   logic [45:0] dx_ff, dx_in, dy_ff, dy_in;
   ctx_type     ctxo_ff;

   always_comb begin
      mx    = 45'({hx_ff, 2'b00}) + 45'(lx_ff[62:30]);
      my    = 45'({hy_ff, 2'b00}) + 45'(ly_ff[62:30]);
      dx_in = negx_ff ? 46'(0 - {1'b0, mx}) : {1'b0, mx};
      dy_in = negy_ff ? 46'(0 - {1'b0, my}) : {1'b0, my};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ctxo_ff <= ctxf_ff;
      end
   end

   // ---------------- saturating add, output register
   logic [46:0] vx, vy;
   logic        hi_x, lo_x, hi_y, lo_y;
   logic [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0] out_h_ff, out_h_in;
   logic        out_sat_ff, out_sat_in;

   always_comb begin
      vx   = {{15{ctxo_ff.px[31]}}, ctxo_ff.px} + {dx_ff[45], dx_ff};
      vy   = {{15{ctxo_ff.py[31]}}, ctxo_ff.py} + {dy_ff[45], dy_ff};
      hi_x = !vx[46] && (|vx[45:31]);
      lo_x = vx[46] && !(&vx[45:31]);
      hi_y = !vy[46] && (|vy[45:31]);
      lo_y = vy[46] && !(&vy[45:31]);
      out_x_in   = hi_x ? 32'h7FFF_FFFF : (lo_x ? 32'h8000_0000 : vx[31:0]);
      out_y_in   = hi_y ? 32'h7FFF_FFFF : (lo_y ? 32'h8000_0000 : vy[31:0]);
      out_h_in   = ctxo_ff.head_out;
      out_sat_in = hi_x || lo_x || hi_y || lo_y;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_h_ff   <= out_h_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.new_x       = out_x_ff;
   assign rsp_chan.new_y       = out_y_ff;
   assign rsp_chan.new_heading = out_h_ff;
   assign rsp_chan.saturated   = out_sat_ff;

   // ---------------- checks
   `BPP_ASSERT_NORST(a_reset_empty, clock, reset |=> (vld_ff == '0 && !out_valid_ff), "pipeline not empty after reset")
   `BPP_ASSERT(a_stall_cause, clock, reset, !req_chan.ready |-> (vld_ff[LAT-1] && out_valid_ff && !rsp_chan.ready), "input stalled without a full output")
   `BPP_ASSERT(a_sat_limit, clock, reset, (rsp_chan.valid && rsp_chan.saturated) |-> (rsp_chan.new_x == 32'sh7FFF_FFFF || rsp_chan.new_x == 32'sh8000_0000 || rsp_chan.new_y == 32'sh7FFF_FFFF || rsp_chan.new_y == 32'sh8000_0000), "saturated flag without a clipped position")

endmodule

/* rtl/core/bpp_cordic_cell.sv */
// ---------------------------------------------------------------------------
// bpp_cordic_cell
// One registered CORDIC rotation step; floor shifts on x and y.
// ---------------------------------------------------------------------------
module bpp_cordic_cell
   import bpp_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] stage_idx,
   input  cordic_type prev,
   output cordic_type cur
);

   cordic_type         vec_ff;
   cordic_type         vec_in;
   logic signed [32:0] sx;
   logic signed [32:0] sy;
   logic signed [33:0] ang;

   always_comb begin
      sx  = $signed(prev.y) >>> stage_idx;
      sy  = $signed(prev.x) >>> stage_idx;
      ang = atan_of(stage_idx);
      if (!prev.z[33]) begin
         vec_in.x = prev.x - sx;
         vec_in.y = prev.y + sy;
         vec_in.z = prev.z - ang;
      end else begin
         vec_in.x = prev.x + sx;
         vec_in.y = prev.y - sy;
         vec_in.z = prev.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign cur = vec_ff;

endmodule

/* rtl/core/bpp_div_cell.sv */
// ---------------------------------------------------------------------------
// bpp_div_cell
// One registered restoring-division step: one quotient bit per cell.
// ---------------------------------------------------------------------------
module bpp_div_cell
   import bpp_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  div_type prev,
   output div_type cur
);

   div_type     node_ff;
   div_type     node_in;
   logic [55:0] trial;

   always_comb begin
      trial       = {prev.rem, prev.dvd[54]};
      node_in.dvd = {prev.dvd[53:0], 1'b0};
      node_in.dsr = prev.dsr;
      if (trial >= {1'b0, prev.dsr}) begin
         node_in.rem = 55'(trial - {1'b0, prev.dsr});
         node_in.quo = {prev.quo[62:0], 1'b1};
      end else begin
         node_in.rem = trial[54:0];
         node_in.quo = {prev.quo[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         node_ff <= node_in;
      end
   end

   assign cur = node_ff;

endmodule

/* bench/bpp_pose_checker.sv */
// ---------------------------------------------------------------------------
// bpp_pose_checker
// Watches the request, response and register ports of the pose predictor.
// Each accepted request word is run through a bit-exact bicycle model.
// Each accepted response word is compared against the oldest predicted pose.
// ---------------------------------------------------------------------------
module bpp_pose_checker
   import bpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wr_data,
   bpp_req_if          req,
   bpp_rsp_if          rsp,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] heading;
      logic        sat;
   } pose_type;

   localparam longint ATAN_LUT [28] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
   localparam logic [63:0] RAD_SCALE = 64'd683565276;
   localparam logic [63:0] R_LIMIT   = 64'd1099511627775;

   logic [23:0] wheel_base;
   logic [15:0] time_step;
   logic [10:0] straight_thr;
   pose_type    pose_q[$];

   function automatic void rot_sincos(input logic [31:0] ang, output longint co,
                                      output longint si);
      logic        flip;
      logic [31:0] a;
      longint      x, y, z, sx, sy;
      flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      a = flip ? ang + 32'h8000_0000 : ang;
      x = 652032874;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < 28; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         if (z >= 0) begin
            x -= sx; y += sy; z -= ATAN_LUT[i];
         end else begin
            x += sx; y -= sy; z += ATAN_LUT[i];
         end
      end
      co = flip ? -x : x;
      si = flip ? -y : y;
   endfunction

   function automatic logic [63:0] mag_of(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] scaled_prod(input logic [63:0] a, input logic [63:0] b,
                                               input int sh);
      logic [127:0] p;
      p = {64'h0, a} * {64'h0, b};
      return 64'(p >> sh);
   endfunction

   function automatic longint with_sign(input logic [63:0] m, input logic neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] clip_add(input longint p, input longint d,
                                            inout logic sat);
      longint v;
      v = p + d;
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647; sat = 1'b1;
      end
      if (v < -64'sd2147483648) begin
         v = -64'sd2147483648; sat = 1'b1;
      end
      return v[31:0];
   endfunction

   function automatic pose_type next_pose(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic [15:0] head,
                                          input logic signed [23:0] speed,
                                          input logic signed [14:0] steer_in);
      pose_type     res;
      longint       spd, st, c, s, cs, ss, ch, sh, dx, dy;
      logic [31:0]  h32, beta32, half32;
      logic [63:0]  dmag, acs, ass, wb, num, den, q, bm, r, chm;
      logic [127:0] wide;
      logic         negd, negs, negc;
      res.sat = 1'b0;
      spd = longint'(speed);
      st = longint'(steer_in);
      h32 = {head, 16'h0};
      negd = spd < 0;
      dmag = (mag_of(spd) * 64'(time_step) + 64'd32768) >> 16;
      if (st == -16384) st = -16383;   // minus pi/2 folds onto the next code
      if (mag_of(st) <= 64'(straight_thr)) begin
         rot_sincos(h32, c, s);
         dx = with_sign(scaled_prod(dmag, mag_of(c), 30), negd != (c < 0));
         dy = with_sign(scaled_prod(dmag, mag_of(s), 30), negd != (s < 0));
         res.heading = head;
      end else begin
         negs = st < 0;
         rot_sincos(32'(st * 65536), cs, ss);
         acs = mag_of(cs);
         ass = mag_of(ss);
         if (acs == 0) acs = 1;
         if (ass == 0) ass = 1;
         wb = (wheel_base == 0) ? 64'd1 : 64'(wheel_base);
         num = dmag * ass;
         den = wb * acs;
         wide = {32'h0, num, 32'h0} / {64'h0, den};
         q = wide[63:0];
         bm = (q >> 32) * RAD_SCALE + (({32'h0, q[31:0]} * RAD_SCALE) >> 32);
         beta32 = (negd != negs) ? 32'(0 - bm[31:0]) : bm[31:0];
         half32 = {beta32[31], beta32[31:1]};
         rot_sincos(half32, ch, sh);
         r = den / ass;
         if (r > R_LIMIT) r = R_LIMIT;
         chm = scaled_prod(r, mag_of(sh), 29);
         negc = negs != (sh < 0);
         rot_sincos(h32 + half32, c, s);
         dx = with_sign(scaled_prod(chm, mag_of(c), 30), negc != (c < 0));
         dy = with_sign(scaled_prod(chm, mag_of(s), 30), negc != (s < 0));
         res.heading = 16'((h32 + beta32 + 32'h8000) >> 16);
      end
      res.x = clip_add(longint'(px), dx, res.sat);
      res.y = clip_add(longint'(py), dy, res.sat);
      return res;
   endfunction

   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         wheel_base   <= 24'd32768;
         time_step    <= 16'd6554;
         straight_thr <= 11'd10;
         pose_q.delete();
         fail_count   <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WHEEL_BASE:   wheel_base   <= csr_wr_data;
               CSR_TIME_STEP:    time_step    <= csr_wr_data[15:0];
               CSR_STRAIGHT_THR: straight_thr <= csr_wr_data[10:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            pose_q = {pose_q, next_pose(req.pos_x, req.pos_y, req.heading_in,
                                        req.speed, req.steer)};
         if (rsp.valid && rsp.ready) begin
            if (pose_q.size() == 0) begin
               $display("%0t: response word with no pose pending: x=%h y=%h hd=%h sat=%b",
                        $time, rsp.new_x, rsp.new_y, rsp.new_heading, rsp.saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = pose_q.pop_front();
               if (rsp.new_x !== want.x || rsp.new_y !== want.y ||
                   rsp.new_heading !== want.heading || rsp.saturated !== want.sat) begin
                  $display("%0t: pose mismatch exp x=%h y=%h hd=%h sat=%b",
                           $time, want.x, want.y, want.heading, want.sat);
                  $display("%0t:               got x=%h y=%h hd=%h sat=%b",
                           $time, rsp.new_x, rsp.new_y, rsp.new_heading, rsp.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the bicycle pose predictor.
// Directed corner poses, then random poses over several register settings
// and sender/receiver stall mixes; the checker does all the comparing.
// ---------------------------------------------------------------------------
module tb_top;
   import bpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [23:0] csr_wr_data;
   int          fail_count;
   int          words_sent;
   int          words_back;
   int          cycles;
   int          idle_pct;
   int          stall_pct;
   logic [10:0] cur_thr;

   bpp_req_if req_chan ();
   bpp_rsp_if rsp_chan ();

   bicycle_pose_predict_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   bpp_pose_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) words_back++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** bicycle_pose_predict_core: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_word(input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] hd, input logic [23:0] spd,
                            input logic [14:0] st);
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.pos_x      <= px;
      req_chan.pos_y      <= py;
      req_chan.heading_in <= hd;
      req_chan.speed      <= spd;
      req_chan.steer      <= st;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == CSR_STRAIGHT_THR) cur_thr = data[10:0];
      @(negedge clock);
   endtask

   // hold the sender until the pipe has drained, plus its full latency
   task automatic drain;
      req_chan.valid <= 1'b0;
      while (words_back != words_sent) @(negedge clock);
      repeat (LAT + 10) @(negedge clock);
   endtask

   task automatic random_words(input int n);
      logic [14:0] st;
      logic [23:0] spd;
      logic [31:0] px, py;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: st = 15'($signed($urandom_range(0, 2 * cur_thr)) - $signed({1'b0, cur_thr}));
            1: st = 15'($urandom_range(0, 2047) - 1024);
            default: st = 15'($urandom);
         endcase
         spd = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1048575) - 524288);
         px = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 200000000) - 100000000);
         py = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 200000000) - 100000000);
         send_word(px, py, 16'($urandom), spd, st);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_WHEEL_BASE;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.heading_in = '0;
      req_chan.speed = '0;
      req_chan.steer = '0;
      rsp_chan.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      words_sent = 0;
      words_back = 0;
      cycles = 0;
      cur_thr = 11'd10;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // corner poses at reset settings
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 24'h7F_FFFF, 15'sd0);
      send_word(32'h8000_0000, 32'h8000_0000, 16'h8000, 24'h7F_FFFF, 15'sd0);
      send_word(32'h7FFF_F000, 32'h8000_1000, 16'h7FFF, 24'h80_0000, 15'sd5);
      send_word(32'h0, 32'h0, 16'h4000, 24'h01_0000, 15'sd10);
      send_word(32'h0, 32'h0, 16'hC000, 24'h01_0000, -15'sd10);
      send_word(32'h0, 32'h0, 16'h2000, 24'h01_0000, 15'sd11);
      send_word(32'h0, 32'h0, 16'hE000, 24'h01_0000, -15'sd11);
      send_word(32'h1000, 32'hFFFF_0000, 16'h1234, 24'h02_0000, 15'sd16383);
      send_word(32'h1000, 32'hFFFF_0000, 16'h1234, 24'h02_0000, -15'sd16383);
      send_word(32'h1000, 32'hFFFF_0000, 16'h1234, 24'h02_0000, -15'sd16384);
      send_word(32'h1000, 32'h2000, 16'h0100, 24'h0, 15'sd4000);
      send_word(32'h1000, 32'h2000, 16'h0100, 24'hFF_FFFF, -15'sd4000);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 16'h6000, 24'h80_0000, 15'sd8000);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 16'hA000, 24'h7F_FFFF, -15'sd8000);
      send_word(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 24'h00_0001, 15'sd1);
      drain();

      // phase 1: no idling, zero then unit wheel base, maximum time step, zero threshold
      write_reg(CSR_WHEEL_BASE, 24'd0);
      write_reg(CSR_TIME_STEP, 24'd65535);
      write_reg(CSR_STRAIGHT_THR, 24'd0);
      write_reg(CSR_SPARE, 24'hFF_FFFF);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      send_word(32'h0, 32'h0, 16'h0, 24'h01_0000, 15'sd1);
      drain();
      write_reg(CSR_WHEEL_BASE, 24'd1);
      csr_wr_en <= 1'b0;
      drain();
      random_words(110);
      drain();

      // phase 2: sender idle half the time, maximum wheel base, minimum time step, wide threshold
      write_reg(CSR_WHEEL_BASE, 24'hFF_FFFF);
      write_reg(CSR_TIME_STEP, 24'd1);
      write_reg(CSR_STRAIGHT_THR, 24'd1024);
      csr_wr_en <= 1'b0;
      idle_pct = 50;
      @(negedge clock);
      random_words(110);
      drain();

      // phase 3: receiver stalls half the time, defaults
      write_reg(CSR_WHEEL_BASE, 24'd32768);
      write_reg(CSR_TIME_STEP, 24'd6554);
      write_reg(CSR_STRAIGHT_THR, 24'd10);
      csr_wr_en <= 1'b0;
      idle_pct = 0;
      stall_pct = 50;
      @(negedge clock);
      random_words(110);
      drain();

      // phase 4: both sides idle a third of the time, random settings
      write_reg(CSR_WHEEL_BASE, 24'($urandom_range(1, 16777215)));
      write_reg(CSR_TIME_STEP, 24'($urandom_range(1, 65535)));
      write_reg(CSR_STRAIGHT_THR, 24'($urandom_range(0, 1024)));
      csr_wr_en <= 1'b0;
      idle_pct = 33;
      stall_pct = 33;
      @(negedge clock);
      random_words(120);
      drain();

      if (fail_count == 0)
         $display("** bicycle_pose_predict_core: PASSED **");
      else
         $display("** bicycle_pose_predict_core: FAILED **");
      $finish;
   end
endmodule
